FILE: hdl/kvlp_pkg.sv
package kvlp_pkg;

    localparam int DEFAULT_MAX_BUFFER = 65536;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_EQ    = 8'd61;

    localparam logic REC_PAIR = 1'b0;
    localparam logic REC_END  = 1'b1;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'b0001,
        PH_KEY    = 4'b0010,
        PH_VBLANK = 4'b0100,
        PH_VALUE  = 4'b1000
    } t_phase;

    // one queue entry: a pair record, an end record, or both
    typedef struct packed {
        logic        pair;
        logic        endr;
        logic [15:0] key_start;
        logic [15:0] key_length;
        logic [15:0] value_start;
        logic [15:0] value_length;
        logic [15:0] count;
    } t_event;

endpackage

FILE: hdl/kvlp_front.sv
module kvlp_front import kvlp_pkg::*; #(
    parameter int MAX_BUFFER = DEFAULT_MAX_BUFFER
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_ev_valid,
    output t_event     o_ev
);

    localparam int PW = $clog2(MAX_BUFFER);
    localparam logic [PW:0]   MaxLen  = (PW+1)'(MAX_BUFFER);
    localparam logic [PW-1:0] LastPos = PW'(MAX_BUFFER - 1);

    t_phase          r_phase, n_phase;
    logic [PW-1:0]   r_pos, n_pos;
    logic [PW-1:0]   r_ks, n_ks;
    logic [PW-1:0]   r_kl, n_kl;
    logic [PW-1:0]   r_vs, n_vs;
    logic [15:0]     r_cnt, n_cnt;

    logic            blank, eol, eq, pair;
    logic [PW:0]     vlen;
    logic [PW-1:0]   vstart;
    logic [15:0]     cnt_next;

    // distance modulo the buffer size
    function automatic logic [PW-1:0] span(input logic [PW-1:0] from, input logic [PW-1:0] to);
        logic [PW:0] d;
        d = {1'b0, to} - {1'b0, from};
        if (from > to) d = d + MaxLen;
        return d[PW-1:0];
    endfunction

    assign blank = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
    assign eol   = (i_data_byte == CH_CR) || (i_data_byte == CH_LF);
    assign eq    = (i_data_byte == CH_EQ);

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_ks    = r_ks;
        n_kl    = r_kl;
        n_vs    = r_vs;
        pair    = 1'b0;
        vlen    = '0;
        vstart  = r_vs;
        unique case (r_phase)
            PH_LEAD: begin
                if (!(blank || eol)) begin
                    n_ks = r_pos;
                    if (eq) begin
                        n_kl    = '0;
                        n_phase = PH_VBLANK;
                    end else begin
                        n_phase = PH_KEY;
                    end
                end
            end
            PH_KEY: begin
                if (eq) begin
                    n_kl    = span(r_ks, r_pos);
                    n_phase = PH_VBLANK;
                end else if (eol) begin
                    n_phase = PH_LEAD;
                end
            end
            PH_VBLANK: begin
                if (eol) begin
                    n_phase = PH_LEAD;
                end else if (!blank) begin
                    n_vs    = r_pos;
                    vstart  = r_pos;
                    n_phase = PH_VALUE;
                    if (i_last_byte) begin
                        pair = 1'b1;
                        vlen = (PW+1)'(1);
                    end
                end
            end
            PH_VALUE: begin
                if (eol) begin
                    pair    = 1'b1;
                    vlen    = {1'b0, span(r_vs, r_pos)};
                    n_phase = PH_LEAD;
                end else if (i_last_byte) begin
                    // value ends with the final byte, so it is counted too
                    pair = 1'b1;
                    vlen = {1'b0, span(r_vs, r_pos)} + (PW+1)'(1);
                end
            end
            default: n_phase = PH_LEAD;
        endcase

        cnt_next = (pair && r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;
        n_cnt    = cnt_next;

        if (i_last_byte) begin
            n_phase = PH_LEAD;
            n_pos   = '0;
            n_ks    = '0;
            n_kl    = '0;
            n_vs    = '0;
            n_cnt   = '0;
        end else begin
            n_pos = (r_pos == LastPos) ? '0 : r_pos + PW'(1);
        end
    end

    assign o_ev_valid      = i_accept && (pair || i_last_byte);
    assign o_ev.pair         = pair;
    assign o_ev.endr         = i_last_byte;
    assign o_ev.key_start    = 16'(r_ks);
    assign o_ev.key_length   = 16'(r_kl);
    assign o_ev.value_start  = 16'(vstart);
    assign o_ev.value_length = 16'(vlen);
    assign o_ev.count        = cnt_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_pos   <= '0;
            r_ks    <= '0;
            r_kl    <= '0;
            r_vs    <= '0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ks    <= n_ks;
            r_kl    <= n_kl;
            r_vs    <= n_vs;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: hdl/kvlp_queue.sv
module kvlp_queue import kvlp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    input  t_event i_wr_data,
    input  logic   i_rd_en,
    output t_event o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] Depth    = CW'(QUEUE_DEPTH);

    t_event        r_slot [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr, rd;

    assign o_full    = (r_count == Depth);
    assign o_empty   = (r_count == '0);
    assign wr        = i_wr_en && !o_full;
    assign rd        = i_rd_en && !o_empty;
    assign o_rd_data = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + AW'(1);
            if (rd) r_rd_ptr <= (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + AW'(1);
            if (wr && !rd) r_count <= r_count + CW'(1);
            else if (rd && !wr) r_count <= r_count - CW'(1);
        end
    end

endmodule

FILE: hdl/kvlp_back.sv
module kvlp_back import kvlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_event      i_head,
    input  logic        i_head_valid,
    input  logic        i_pop,
    output logic        o_deq,
    output logic        o_empty,
    output logic        o_rec_kind,
    output logic [15:0] o_key_start,
    output logic [15:0] o_key_length,
    output logic [15:0] o_value_start,
    output logic [15:0] o_value_length,
    output logic [15:0] o_prop_count,
    output logic        o_last_result
);

    // set once the pair word of a two-word entry has gone out
    logic r_sub;
    logic show_pair, take, split;

    assign show_pair = i_head.pair && !r_sub;
    assign split     = show_pair && i_head.endr;
    assign take      = i_head_valid && i_pop;
    assign o_deq     = take && !split;
    assign o_empty   = !i_head_valid;

    assign o_rec_kind     = show_pair ? REC_PAIR : REC_END;
    assign o_key_start    = show_pair ? i_head.key_start    : 16'd0;
    assign o_key_length   = show_pair ? i_head.key_length   : 16'd0;
    assign o_value_start  = show_pair ? i_head.value_start  : 16'd0;
    assign o_value_length = show_pair ? i_head.value_length : 16'd0;
    assign o_prop_count   = i_head.count;
    assign o_last_result  = !split;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (take) begin
            r_sub <= split;
        end
    end

endmodule

FILE: hdl/key_value_line_parser.sv
// A byte's word is queued when the byte is taken and is output after the words ahead of it
// are popped. Throughput: one byte per cycle while the queue is not full; the parse state
// is a single register stage. A final byte that closes a value gives two words, popped in
// turn; a 4-entry queue between parser and output absorbs these while bytes keep flowing.
// Reset (synchronous, active low) returns the parser to offset 0 and empties the queue.
module key_value_line_parser import kvlp_pkg::*; #(
    parameter int MAX_BUFFER = DEFAULT_MAX_BUFFER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_rec_kind,
    output logic [15:0] o_key_start,
    output logic [15:0] o_key_length,
    output logic [15:0] o_value_start,
    output logic [15:0] o_value_length,
    output logic [15:0] o_prop_count,
    output logic        o_last_result
);

    logic   accept, ev_valid, deq, q_empty;
    t_event ev, head;

    assign accept = push && !full;

    kvlp_front #(.MAX_BUFFER(MAX_BUFFER)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_ev_valid  (ev_valid),
        .o_ev        (ev)
    );

    kvlp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (ev_valid),
        .i_wr_data (ev),
        .i_rd_en   (deq),
        .o_rd_data (head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    kvlp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (!q_empty),
        .i_pop          (pop),
        .o_deq          (deq),
        .o_empty        (empty),
        .o_rec_kind     (o_rec_kind),
        .o_key_start    (o_key_start),
        .o_key_length   (o_key_length),
        .o_value_start  (o_value_start),
        .o_value_length (o_value_length),
        .o_prop_count   (o_prop_count),
        .o_last_result  (o_last_result)
    );

    a_end_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rec_kind == REC_END) |->
            (o_key_start == 16'd0 && o_key_length == 16'd0 && o_value_start == 16'd0
             && o_value_length == 16'd0 && o_last_result))
        else $error("end word carries pair fields or is not last");

    a_pair_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_rec_kind == REC_PAIR && !o_last_result) |=>
            (!empty && o_rec_kind == REC_END))
        else $error("split pair word not followed by end word");

    a_pair_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rec_kind == REC_PAIR) |-> (o_prop_count != 16'd0))
        else $error("pair word with zero count");

endmodule
